[hw/rtl/z80ltp_pkg.sv]
// Package for the Z80 length and timing predecoder.
// Holds the opcode group codes, the decode result type and the timing tables.
// No dependencies.
package z80ltp_pkg;

  // prefix and special opcodes
  localparam logic [7:0] OP_CB   = 8'hCB;
  localparam logic [7:0] OP_ED   = 8'hED;
  localparam logic [7:0] OP_DD   = 8'hDD;
  localparam logic [7:0] OP_FD   = 8'hFD;
  localparam logic [7:0] OP_HALT = 8'h76;

  // field widths
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned TS_W   = 5;

  // legal length range of a word
  localparam logic [LEN_W-1:0] LEN_MIN = 3'd1;
  localparam logic [LEN_W-1:0] LEN_MAX = 3'd4;

  // prefix group of a fetched window
  typedef enum logic [2:0] {
    GRP_MAIN,
    GRP_CB,
    GRP_XY,
    GRP_XYCB,
    GRP_ED
  } grp_t;

  // length and timing of one decoded instruction
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [TS_W-1:0]  base;
    logic [TS_W-1:0]  taken;
  } dec_t;

  // base T-states: opcodes 00-3F, then C0-FF; zero marks a prefix byte
  localparam logic [TS_W-1:0] EDGE_TS [128] = '{
    5'd4, 5'd10, 5'd7,  5'd6,  5'd4,  5'd4,  5'd7,  5'd4,
    5'd4, 5'd11, 5'd7,  5'd6,  5'd4,  5'd4,  5'd7,  5'd4,
    5'd8, 5'd10, 5'd7,  5'd6,  5'd4,  5'd4,  5'd7,  5'd4,
    5'd12,5'd11, 5'd7,  5'd6,  5'd4,  5'd4,  5'd7,  5'd4,
    5'd7, 5'd10, 5'd16, 5'd6,  5'd4,  5'd4,  5'd7,  5'd4,
    5'd7, 5'd11, 5'd16, 5'd6,  5'd4,  5'd4,  5'd7,  5'd4,
    5'd7, 5'd10, 5'd13, 5'd6,  5'd11, 5'd11, 5'd10, 5'd4,
    5'd7, 5'd11, 5'd13, 5'd6,  5'd4,  5'd4,  5'd7,  5'd4,
    5'd5, 5'd10, 5'd10, 5'd10, 5'd10, 5'd11, 5'd7,  5'd11,
    5'd5, 5'd10, 5'd10, 5'd0,  5'd10, 5'd17, 5'd7,  5'd11,
    5'd5, 5'd10, 5'd10, 5'd11, 5'd10, 5'd11, 5'd7,  5'd11,
    5'd5, 5'd4,  5'd10, 5'd11, 5'd10, 5'd0,  5'd7,  5'd11,
    5'd5, 5'd10, 5'd10, 5'd19, 5'd10, 5'd11, 5'd7,  5'd11,
    5'd5, 5'd4,  5'd10, 5'd4,  5'd10, 5'd0,  5'd7,  5'd11,
    5'd5, 5'd10, 5'd10, 5'd4,  5'd10, 5'd11, 5'd7,  5'd11,
    5'd5, 5'd6,  5'd10, 5'd4,  5'd10, 5'd0,  5'd7,  5'd11
  };

  // unprefixed base T-states, zero for prefix bytes
  function automatic logic [TS_W-1:0] main_base(input logic [7:0] op);
    logic [TS_W-1:0] ts;
    if (op[7:6] == 2'b00 || op[7:6] == 2'b11) begin
      ts = EDGE_TS[{op[7], op[5:0]}];
    end else if (op[7:3] == 5'b01110) begin
      ts = (op == OP_HALT) ? 5'd4 : 5'd7;
    end else begin
      ts = (op[2:0] == 3'd6) ? 5'd7 : 5'd4;
    end
    return ts;
  endfunction

  // unprefixed T-states when the branch is taken, zero if the same
  function automatic logic [TS_W-1:0] main_taken(input logic [7:0] op);
    logic [TS_W-1:0] ts;
    if (op == 8'h10) begin
      ts = 5'd13;
    end else if (op == 8'h20 || op == 8'h28 || op == 8'h30 || op == 8'h38) begin
      ts = 5'd12;
    end else if (op[7:6] == 2'b11 && op[2:0] == 3'd0) begin
      ts = 5'd11;
    end else if (op[7:6] == 2'b11 && op[2:0] == 3'd4) begin
      ts = 5'd17;
    end else begin
      ts = 5'd0;
    end
    return ts;
  endfunction

  // unprefixed length
  function automatic logic [LEN_W-1:0] main_len(input logic [7:0] op);
    logic [LEN_W-1:0] len;
    if (op[7:6] == 2'b00) begin
      if (op[3:0] == 4'd1 || op == 8'h22 || op == 8'h2A || op == 8'h32 || op == 8'h3A) begin
        len = 3'd3;
      end else if (op[2:0] == 3'd6) begin
        len = 3'd2;
      end else if (op[5:4] != 2'b00 && op[2:0] == 3'd0) begin
        len = 3'd2;
      end else begin
        len = 3'd1;
      end
    end else if (op[7:6] != 2'b11) begin
      len = 3'd1;
    end else if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op == 8'hC3 || op == 8'hCD) begin
      len = 3'd3;
    end else if (op[2:0] == 3'd6 || op == 8'hD3 || op == 8'hDB) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // unprefixed decode
  function automatic dec_t main_dec(input logic [7:0] op);
    dec_t d;
    d.len   = main_len(op);
    d.base  = main_base(op);
    d.taken = main_taken(op);
    if (d.base == 5'd0) begin
      d.base = 5'd4;
    end
    return d;
  endfunction

  // ED group: op is the byte after the prefix
  function automatic dec_t ed_dec(input logic [7:0] op);
    dec_t d;
    d.taken = 5'd0;
    d.len   = (op[7:6] == 2'b01 && op[2:0] == 3'd3) ? 3'd4 : 3'd2;
    if (op[7:6] == 2'b01) begin
      unique case (op[2:0])
        3'd0, 3'd1: d.base = 5'd12;
        3'd2:       d.base = 5'd15;
        3'd3:       d.base = 5'd20;
        3'd5:       d.base = 5'd14;
        3'd7: begin
          if (op == 8'h47 || op == 8'h4F || op == 8'h57 || op == 8'h5F) begin
            d.base = 5'd9;
          end else if (op == 8'h67 || op == 8'h6F) begin
            d.base = 5'd18;
          end else begin
            d.base = 5'd8;
          end
        end
        default:    d.base = 5'd8;
      endcase
    end else if ((op & 8'hE4) == 8'hA0) begin
      // block transfer, search and I/O; repeat forms may loop
      d.base = 5'd16;
      if (op[4]) begin
        d.taken = 5'd21;
      end
    end else begin
      d.base = 5'd8;
    end
    return d;
  endfunction

  // DD/FD group: op is the byte after the prefix (not CB)
  function automatic dec_t xy_dec(input logic [7:0] op);
    dec_t d;
    logic mem;
    logic [TS_W-1:0] b;
    logic [TS_W-1:0] t;
    d.len   = 3'd2;
    d.taken = 5'd0;
    d.base  = 5'd8;
    mem     = (op[2:0] == 3'd6) || (op[7:6] == 2'b01 && op[5:3] == 3'd6);
    b       = main_base(op);
    t       = main_taken(op);
    if (op[7:6] == 2'b01 || op[7:6] == 2'b10) begin
      d.base = mem ? 5'd19 : 5'd8;
      if (mem && op != OP_HALT) begin
        d.len = 3'd3;
      end
    end else begin
      unique case (op)
        8'h21: begin d.len = 3'd4; d.base = 5'd14; end
        8'h22, 8'h2A: begin d.len = 3'd4; d.base = 5'd20; end
        8'h09, 8'h19, 8'h29, 8'h39: d.base = 5'd15;
        8'h23, 8'h2B: d.base = 5'd10;
        8'h24, 8'h25, 8'h2C, 8'h2D: d.base = 5'd8;
        8'h26, 8'h2E: begin d.len = 3'd3; d.base = 5'd11; end
        8'h34, 8'h35: begin d.len = 3'd3; d.base = 5'd23; end
        8'h36: begin d.len = 3'd4; d.base = 5'd19; end
        8'hE1: d.base = 5'd14;
        8'hE5: d.base = 5'd15;
        8'hE3: d.base = 5'd23;
        8'hE9: d.base = 5'd8;
        8'hF9: d.base = 5'd10;
        default: begin
          // no IX/IY form: plain timing plus the prefix fetch
          d.base  = (b != 5'd0) ? b + 5'd4 : 5'd8;
          d.taken = (t != 5'd0) ? t + 5'd4 : 5'd0;
        end
      endcase
    end
    return d;
  endfunction

endpackage

[hw/rtl/z80_length_and_timing_predecoder.sv]
// Z80 length and timing predecoder, top level.
// Three-stage pipeline; uses z80ltp_pkg for group codes and decode tables.
//
// One fetched window (address and four bytes) is taken in every clock cycle;
// busy is always low. Each word gives one result, strobed by out_valid for one
// cycle once it has passed through the register stages, in order. The three
// register stages are: prefix grouping and relative target add, table decode
// of every group, and group select into the output register. The receiver
// cannot stall, so results are never held.
module z80_length_and_timing_predecoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_instr_addr,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic [7:0]  in_third_byte,
  input  logic [7:0]  in_fourth_byte,
  output logic        out_valid,
  output logic [2:0]  out_instr_length,
  output logic [4:0]  out_base_tstates,
  output logic [4:0]  out_taken_tstates,
  output logic        out_has_relative,
  output logic [15:0] out_relative_target
);

  // stage 1 registers
  logic                s1_valid_r;
  z80ltp_pkg::grp_t    s1_grp_r;
  logic [7:0]          s1_b0_r;
  logic [7:0]          s1_b1_r;
  logic [7:0]          s1_b3_r;
  logic                s1_rel_r;
  logic [15:0]         s1_target_r;

  // stage 2 registers
  logic                s2_valid_r;
  z80ltp_pkg::grp_t    s2_grp_r;
  z80ltp_pkg::dec_t    s2_main_r;
  z80ltp_pkg::dec_t    s2_xy_r;
  z80ltp_pkg::dec_t    s2_ed_r;
  logic [4:0]          s2_cb_ts_r;
  logic [4:0]          s2_xycb_ts_r;
  logic                s2_rel_r;
  logic [15:0]         s2_target_r;

  // stage 3 (output) registers
  logic                out_valid_r;
  z80ltp_pkg::dec_t    out_dec_r;
  logic                out_rel_r;
  logic [15:0]         out_target_r;

  z80ltp_pkg::grp_t    s1_grp_nxt;
  logic                s1_rel_nxt;
  logic [15:0]         s1_target_nxt;
  logic [4:0]          s2_cb_ts_nxt;
  logic [4:0]          s2_xycb_ts_nxt;
  z80ltp_pkg::dec_t    out_dec_nxt;
  logic                accept;

  // the pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: prefix group and relative branch target
  always_comb begin
    if (in_first_byte == z80ltp_pkg::OP_CB) begin
      s1_grp_nxt = z80ltp_pkg::GRP_CB;
    end else if (in_first_byte == z80ltp_pkg::OP_DD || in_first_byte == z80ltp_pkg::OP_FD) begin
      s1_grp_nxt = (in_second_byte == z80ltp_pkg::OP_CB) ? z80ltp_pkg::GRP_XYCB
                                                          : z80ltp_pkg::GRP_XY;
    end else if (in_first_byte == z80ltp_pkg::OP_ED) begin
      s1_grp_nxt = z80ltp_pkg::GRP_ED;
    end else begin
      s1_grp_nxt = z80ltp_pkg::GRP_MAIN;
    end
  end

  // DJNZ, JR and JR cc: 10,18,20,28,30,38
  assign s1_rel_nxt = (in_first_byte[7:6] == 2'b00) && (in_first_byte[5:4] != 2'b00) &&
                      (in_first_byte[2:0] == 3'd0);
  assign s1_target_nxt = s1_rel_nxt ?
      (in_instr_addr + 16'd2 + {{8{in_second_byte[7]}}, in_second_byte}) : 16'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_grp_r    <= s1_grp_nxt;
    s1_b0_r     <= in_first_byte;
    s1_b1_r     <= in_second_byte;
    s1_b3_r     <= in_fourth_byte;
    s1_rel_r    <= s1_rel_nxt;
    s1_target_r <= s1_target_nxt;
  end

  // stage 2: decode every group in parallel
  always_comb begin
    if (s1_b1_r[2:0] == 3'd6) begin
      s2_cb_ts_nxt = (s1_b1_r[7:6] == 2'b01) ? 5'd12 : 5'd15;
    end else begin
      s2_cb_ts_nxt = 5'd8;
    end
    s2_xycb_ts_nxt = (s1_b3_r[7:6] == 2'b01) ? 5'd20 : 5'd23;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_grp_r     <= s1_grp_r;
    s2_main_r    <= z80ltp_pkg::main_dec(s1_b0_r);
    s2_xy_r      <= z80ltp_pkg::xy_dec(s1_b1_r);
    s2_ed_r      <= z80ltp_pkg::ed_dec(s1_b1_r);
    s2_cb_ts_r   <= s2_cb_ts_nxt;
    s2_xycb_ts_r <= s2_xycb_ts_nxt;
    s2_rel_r     <= s1_rel_r;
    s2_target_r  <= s1_target_r;
  end

  // stage 3: select by group
  always_comb begin
    unique case (s2_grp_r)
      z80ltp_pkg::GRP_CB:   out_dec_nxt = '{len: 3'd2, base: s2_cb_ts_r, taken: 5'd0};
      z80ltp_pkg::GRP_XY:   out_dec_nxt = s2_xy_r;
      z80ltp_pkg::GRP_XYCB: out_dec_nxt = '{len: 3'd4, base: s2_xycb_ts_r, taken: 5'd0};
      z80ltp_pkg::GRP_ED:   out_dec_nxt = s2_ed_r;
      default:              out_dec_nxt = s2_main_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
    out_dec_r    <= out_dec_nxt;
    out_rel_r    <= s2_rel_r && (s2_grp_r == z80ltp_pkg::GRP_MAIN);
    out_target_r <= (s2_grp_r == z80ltp_pkg::GRP_MAIN) ? s2_target_r : 16'd0;
  end

  assign out_valid           = out_valid_r;
  assign out_instr_length    = out_dec_r.len;
  assign out_base_tstates    = out_dec_r.base;
  assign out_taken_tstates   = out_dec_r.taken;
  assign out_has_relative    = out_rel_r;
  assign out_relative_target = out_target_r;

endmodule

[hw/rtl/z80ltp_checker.sv]
// Port-level checker for the Z80 length and timing predecoder, and its bind.
// Uses z80ltp_pkg for the legal length range.
module z80ltp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_instr_addr,
  input logic [7:0]  in_second_byte,
  input logic        out_valid,
  input logic [2:0]  out_instr_length,
  input logic        out_has_relative,
  input logic [15:0] out_relative_target
);

  // every accepted word comes out as a result strobe once through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted word produced no result after three cycles");

  // no result without an accepted word
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobe without an accepted word");

  // length within range
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_instr_length >= z80ltp_pkg::LEN_MIN &&
                   out_instr_length <= z80ltp_pkg::LEN_MAX))
    else $error("instruction length out of range");

  // relative target follows the address and offset of the word that produced this result
  a_rel_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_relative) |->
      (out_instr_length == 3'd2 &&
       out_relative_target == 16'($past(in_instr_addr, 3) + 16'd2 +
                                  {{8{$past(in_second_byte[7], 3)}}, $past(in_second_byte, 3)})))
    else $error("relative branch target mismatch");

  // no relative target outside branch forms
  a_rel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_relative) |-> (out_relative_target == 16'd0))
    else $error("relative target set without a relative branch");

endmodule

bind z80_length_and_timing_predecoder z80ltp_checker u_z80ltp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_instr_addr       (in_instr_addr),
  .in_second_byte      (in_second_byte),
  .out_valid           (out_valid),
  .out_instr_length    (out_instr_length),
  .out_has_relative    (out_has_relative),
  .out_relative_target (out_relative_target)
);

[bench/z80ltp_decode_checker.sv]
// Checker for the Z80 length and timing predecoder: predicts each word's decode
// from the fetched window and compares it with the strobed result, oldest first.
// Depends on z80ltp_pkg for opcode constants and field widths.
module z80ltp_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] in_instr_addr,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic [7:0]  in_third_byte,
  input  logic [7:0]  in_fourth_byte,
  input  logic        out_valid,
  input  logic [2:0]  out_instr_length,
  input  logic [4:0]  out_base_tstates,
  input  logic [4:0]  out_taken_tstates,
  input  logic        out_has_relative,
  input  logic [15:0] out_relative_target,
  output int          fail_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  import z80ltp_pkg::*;

  localparam logic [7:0] OP_DJNZ = 8'h10;
  localparam logic [7:0] OP_JR_C = 8'h38;

  // decoded view of one fetched window
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [TS_W-1:0]   base;
    logic [TS_W-1:0]   taken;
    logic              rel;
    logic [ADDR_W-1:0] target;
  } window_decode_t;

  // plain opcode timing: 00-3F first, then C0-FF; zero marks a prefix
  localparam logic [TS_W-1:0] PLAIN_TS [128] = '{
    4,10,7,6,4,4,7,4,   4,11,7,6,4,4,7,4,
    8,10,7,6,4,4,7,4,   12,11,7,6,4,4,7,4,
    7,10,16,6,4,4,7,4,  7,11,16,6,4,4,7,4,
    7,10,13,6,11,11,10,4, 7,11,13,6,4,4,7,4,
    5,10,10,10,10,11,7,11, 5,10,10,0,10,17,7,11,
    5,10,10,11,10,11,7,11, 5,4,10,11,10,0,7,11,
    5,10,10,19,10,11,7,11, 5,4,10,4,10,0,7,11,
    5,10,10,4,10,11,7,11,  5,6,10,4,10,0,7,11
  };

  window_decode_t expected_decodes[$];
  int errors = 0;
  int waiting = 0;

  assign fail_count    = errors;
  assign pending_words = waiting;

  function automatic int plain_base(input logic [7:0] op);
    if (op < 8'h40) return PLAIN_TS[int'(op)];
    if (op >= 8'hC0) return PLAIN_TS[64 + int'(op) - 192];
    if (op >= 8'h70 && op <= 8'h77) return (op == OP_HALT) ? 4 : 7;
    return (op[2:0] == 3'd6) ? 7 : 4;
  endfunction

  function automatic int plain_taken(input logic [7:0] op);
    if (op == OP_DJNZ) return 13;
    // JR NZ/Z/NC/C
    if (op >= 8'h20 && op <= OP_JR_C && op[2:0] == 3'd0) return 12;
    if (op >= 8'hC0 && op[2:0] == 3'd0) return 11;
    if (op >= 8'hC0 && op[2:0] == 3'd4) return 17;
    return 0;
  endfunction

  function automatic int plain_len(input logic [7:0] op);
    if (op < 8'h40) begin
      if (op[3:0] == 4'h1 || op == 8'h22 || op == 8'h2A || op == 8'h32 || op == 8'h3A) return 3;
      if (op[2:0] == 3'd6) return 2;
      if (op >= OP_DJNZ && op[2:0] == 3'd0) return 2;
      return 1;
    end
    if (op < 8'hC0) return 1;
    if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op == 8'hC3 || op == 8'hCD) return 3;
    if (op[2:0] == 3'd6 || op == 8'hD3 || op == 8'hDB) return 2;
    return 1;
  endfunction

  // ED group, op is the byte after the prefix
  function automatic window_decode_t ed_timing(input logic [7:0] op);
    window_decode_t d;
    d = '0;
    d.len = (op >= 8'h40 && op <= 8'h7F && op[2:0] == 3'd3) ? 3'd4 : 3'd2;
    if (op >= 8'h40 && op <= 8'h7F) begin
      case (op[2:0])
        3'd0, 3'd1: d.base = 5'd12;
        3'd2:       d.base = 5'd15;
        3'd3:       d.base = 5'd20;
        3'd5:       d.base = 5'd14;
        3'd7: begin
          if (op == 8'h47 || op == 8'h4F || op == 8'h57 || op == 8'h5F) d.base = 5'd9;
          else if (op == 8'h67 || op == 8'h6F) d.base = 5'd18;
          else d.base = 5'd8;
        end
        default:    d.base = 5'd8;
      endcase
    end else if ((op & 8'hE4) == 8'hA0) begin
      // block ops; the repeating forms loop
      d.base = 5'd16;
      if (op >= 8'hB0) d.taken = 5'd21;
    end else begin
      d.base = 5'd8;
    end
    return d;
  endfunction

  // DD/FD group, op is the byte after the prefix (not CB)
  function automatic window_decode_t index_decode(input logic [7:0] op);
    window_decode_t d;
    logic mem;
    int b;
    int t;
    d = '0;
    d.len = 3'd2;
    if (op >= 8'h40 && op < 8'hC0) begin
      mem = (op[2:0] == 3'd6) || (op < 8'h80 && op[5:3] == 3'd6);
      d.base = mem ? 5'd19 : 5'd8;
      if (mem && op != OP_HALT) d.len = 3'd3;
      return d;
    end
    case (op)
      8'h21:                      begin d.len = 3'd4; d.base = 5'd14; end
      8'h22, 8'h2A:               begin d.len = 3'd4; d.base = 5'd20; end
      8'h09, 8'h19, 8'h29, 8'h39: d.base = 5'd15;
      8'h23, 8'h2B:               d.base = 5'd10;
      8'h24, 8'h25, 8'h2C, 8'h2D: d.base = 5'd8;
      8'h26, 8'h2E:               begin d.len = 3'd3; d.base = 5'd11; end
      8'h34, 8'h35:               begin d.len = 3'd3; d.base = 5'd23; end
      8'h36:                      begin d.len = 3'd4; d.base = 5'd19; end
      8'hE1:                      d.base = 5'd14;
      8'hE5:                      d.base = 5'd15;
      8'hE3:                      d.base = 5'd23;
      8'hE9:                      d.base = 5'd8;
      8'hF9:                      d.base = 5'd10;
      default: begin
        // no indexed form: plain timing plus the prefix fetch
        b = plain_base(op);
        t = plain_taken(op);
        d.base  = (b != 0) ? TS_W'(b + 4) : 5'd8;
        d.taken = (t != 0) ? TS_W'(t + 4) : 5'd0;
      end
    endcase
    return d;
  endfunction

  function automatic window_decode_t predict_window(input logic [15:0] addr,
      input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b3);
    window_decode_t d;
    d = '0;
    if (b0 == OP_CB) begin
      d.len = 3'd2;
      if (b1[2:0] == 3'd6) d.base = (b1[7:6] == 2'b01) ? 5'd12 : 5'd15;
      else d.base = 5'd8;
    end else if (b0 == OP_DD || b0 == OP_FD) begin
      if (b1 == OP_CB) begin
        d.len  = 3'd4;
        d.base = (b3[7:6] == 2'b01) ? 5'd20 : 5'd23;
      end else begin
        d = index_decode(b1);
      end
    end else if (b0 == OP_ED) begin
      d = ed_timing(b1);
    end else begin
      d.len   = LEN_W'(plain_len(b0));
      d.base  = TS_W'(plain_base(b0));
      d.taken = TS_W'(plain_taken(b0));
      if (d.base == 5'd0) d.base = 5'd4;
      // DJNZ, JR, JR cc: target from the sign-extended offset
      if (b0 >= OP_DJNZ && b0 < 8'h40 && b0[2:0] == 3'd0) begin
        d.rel    = 1'b1;
        d.target = addr + 16'd2 + {{8{b1[7]}}, b1};
      end
    end
    return d;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
      input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  // compare the strobed word first, then log the word taken at this edge
  always @(posedge clk) begin
    window_decode_t want;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        errors++;
        $display("%0t ns: out_valid expected 0 or 1 got %b", $time, out_valid);
      end else if (out_valid) begin
        if (expected_decodes.size() == 0) begin
          errors++;
          $display("%0t ns: result word expected none got length %0d", $time,
                   out_instr_length);
        end else begin
          want = expected_decodes.pop_front();
          check_field("instr_length", 16'(want.len), 16'(out_instr_length));
          check_field("base_tstates", 16'(want.base), 16'(out_base_tstates));
          check_field("taken_tstates", 16'(want.taken), 16'(out_taken_tstates));
          check_field("has_relative", 16'(want.rel), 16'(out_has_relative));
          check_field("relative_target", want.target, out_relative_target);
        end
      end
      if (start && !busy) begin
        expected_decodes.push_back(predict_window(in_instr_addr, in_first_byte,
                                                  in_second_byte, in_fourth_byte));
      end
    end
    waiting = expected_decodes.size();
  end

endmodule

[bench/testbench.sv]
// Top of the predecoder bench: clock, reset, directed and random fetch windows.
// Depends on z80ltp_pkg, the predecoder and z80ltp_decode_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import z80ltp_pkg::*;

  localparam int RANDOM_WORDS   = 2000;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_instr_addr = '0;
  logic [7:0]  in_first_byte = '0;
  logic [7:0]  in_second_byte = '0;
  logic [7:0]  in_third_byte = '0;
  logic [7:0]  in_fourth_byte = '0;
  logic        out_valid;
  logic [2:0]  out_instr_length;
  logic [4:0]  out_base_tstates;
  logic [4:0]  out_taken_tstates;
  logic        out_has_relative;
  logic [15:0] out_relative_target;
  int          fail_count;
  int          pending_words;
  int          quiet_cycles = 0;
  int          burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  z80_length_and_timing_predecoder dut (.*);

  z80ltp_decode_checker checker_i (.*);

  // watchdog: no word moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // idle length after a word: mostly none or short, a few long, some bursts
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    if (r < 97) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [15:0] addr, input logic [7:0] b0,
      input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
    int unsigned gap;
    start          <= 1'b1;
    in_instr_addr  <= addr;
    in_first_byte  <= b0;
    in_second_byte <= b1;
    in_third_byte  <= b2;
    in_fourth_byte <= b3;
    do @(posedge clk); while (busy);
    gap = next_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random window weighted toward the prefix groups and relative branches
  task automatic send_random_word();
    logic [15:0] addr;
    logic [7:0]  b0;
    logic [7:0]  b1;
    int unsigned pick;
    addr = 16'($urandom);
    b0   = 8'($urandom);
    b1   = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // any first byte
    end else if (pick < 55) begin
      b0 = OP_CB;
    end else if (pick < 75) begin
      b0 = $urandom_range(0, 1) ? OP_DD : OP_FD;
      if ($urandom_range(0, 4) == 0) b1 = OP_CB;
    end else if (pick < 90) begin
      b0 = OP_ED;
      if ($urandom_range(0, 1) == 0) b1 = 8'($urandom_range(8'h40, 8'h7F));
    end else begin
      // DJNZ, JR and JR cc; addresses near the ends to wrap the target
      b0 = 8'(8'h10 + 8 * $urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) addr = {($urandom_range(0, 1) ? 8'hFF : 8'h00), addr[7:0]};
    end
    send_word(addr, b0, b1, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, relative wrap, each prefix group
    send_word(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(16'hFFFF, 8'h18, 8'h7F, 8'h00, 8'h00);
    send_word(16'h0000, 8'h18, 8'h80, 8'hFF, 8'hFF);
    send_word(16'h1234, 8'h10, 8'hFE, 8'h00, 8'h00);
    send_word(16'h8000, 8'h38, 8'h00, 8'h00, 8'h00);
    send_word(16'h0100, OP_HALT, 8'h00, 8'h00, 8'h00);
    send_word(16'h0200, 8'hCD, 8'h34, 8'h12, 8'h00);
    send_word(16'h0300, 8'hDB, 8'hFE, 8'h00, 8'h00);
    send_word(16'h0400, OP_CB, 8'h06, 8'h00, 8'h00);
    send_word(16'h0401, OP_CB, 8'h46, 8'h00, 8'h00);
    send_word(16'h0402, OP_CB, 8'h01, 8'h00, 8'h00);
    send_word(16'h0500, OP_DD, OP_CB, 8'h05, 8'h46);
    send_word(16'h0504, OP_FD, OP_CB, 8'hFB, 8'hC6);
    send_word(16'h0600, OP_DD, OP_HALT, 8'h00, 8'h00);
    send_word(16'h0602, OP_FD, 8'h34, 8'h80, 8'h00);
    send_word(16'h0605, OP_DD, 8'h36, 8'h7F, 8'hAA);
    send_word(16'h0700, OP_DD, 8'h00, 8'h00, 8'h00);
    send_word(16'h0702, OP_FD, 8'h10, 8'h05, 8'h00);
    send_word(16'h0704, OP_DD, 8'hC4, 8'h00, 8'h10);
    send_word(16'h0706, OP_DD, OP_DD, 8'h00, 8'h00);
    send_word(16'h0800, OP_ED, 8'h43, 8'h00, 8'h80);
    send_word(16'h0804, OP_ED, 8'h00, 8'h00, 8'h00);
    send_word(16'h0806, OP_ED, 8'hB0, 8'h00, 8'h00);
    send_word(16'h0808, OP_ED, 8'h67, 8'h00, 8'h00);

    repeat (RANDOM_WORDS) send_random_word();
    start <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
